// ===== hdl/xorshift64_star_range_generator_core_defines.svh =====
// Assertion helpers shared by the generator RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef XORSHIFT64_STAR_RANGE_GENERATOR_CORE_DEFINES_SVH
`define XORSHIFT64_STAR_RANGE_GENERATOR_CORE_DEFINES_SVH

// Implication checked on every edge outside reset.
`define XRG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/xrg_pkg.sv =====
package xrg_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned FracW = 28;
  localparam int unsigned CntW  = $clog2(DataW);

  localparam int unsigned ShiftA = 12;
  localparam int unsigned ShiftB = 25;
  localparam int unsigned ShiftC = 27;

  localparam logic [DataW-1:0] MixMult   = 64'h2545_F491_4F6C_DD1D;
  localparam logic [DataW-1:0] SeedReset = 64'd1;

  // request kinds
  localparam logic CmdInt  = 1'b0;
  localparam logic CmdFrac = 1'b1;

  // last count value of each sequencer phase
  localparam logic [CntW-1:0] XorLast = CntW'(2);
  localparam logic [CntW-1:0] MulLast = CntW'(3);
  localparam logic [CntW-1:0] DivLast = CntW'(DataW - 1);

  // partial product / shift step selects
  localparam logic [1:0] Step0 = 2'd0;
  localparam logic [1:0] Step1 = 2'd1;
  localparam logic [1:0] Step2 = 2'd2;
  localparam logic [1:0] Step3 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XOR,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load;
    logic       xor_en;
    logic       mul_en;
    logic       div_en;
    logic       out_load;
    logic [1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic frac;
    logic span_zero;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/xrg_req_if.sv =====
interface xrg_req_if;
  import xrg_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [DataW-1:0] range_low;
  logic [DataW-1:0] range_high;

  modport source (output valid, cmd, range_low, range_high, input ready);
  modport sink   (input valid, cmd, range_low, range_high, output ready);
endinterface

// ===== hdl/xrg_rsp_if.sv =====
interface xrg_rsp_if;
  import xrg_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] value;
  logic [FracW-1:0] fraction;
  logic             span_error;

  modport source (output valid, value, fraction, span_error, input ready);
  modport sink   (input valid, value, fraction, span_error, output ready);
endinterface

// ===== hdl/xorshift64_star_range_generator_core.sv =====
// Seeded xorshift64* generator with range reduction. Each accepted item runs
// three xorshift steps on a shared shifter, a 64-bit multiply as three
// 32x32 partial products on one shared multiplier and, for an integer
// request with nonzero span, a restoring modulo of one bit per cycle, then
// loads the output register once it is free. A fraction request or a zero
// span skips the divider, so integer items occupy the block longest and the
// divider sets the rate. The block takes one item at a time; a finished
// result waits in the output register while the next item is accepted.
// Writing the seed reloads the generator state; write it only when idle.
module xorshift64_star_range_generator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [xrg_pkg::DataW-1:0] cfg_wdata_i,
  xrg_req_if.sink                   req_i,
  xrg_rsp_if.source                 rsp_o
);
  import xrg_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    req_ready;

  assign req_i.ready = req_ready;

  xrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  xrg_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_cmd_i        (req_i.cmd),
    .req_range_low_i  (req_i.range_low),
    .req_range_high_i (req_i.range_high),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_value_o      (rsp_o.value),
    .rsp_fraction_o   (rsp_o.fraction),
    .rsp_span_error_o (rsp_o.span_error)
  );

endmodule

// ===== hdl/xrg_ctrl.sv =====
`include "xorshift64_star_range_generator_core_defines.svh"

module xrg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  xrg_pkg::status_t status_i,
  output xrg_pkg::ctrl_t   ctrl_o
);
  import xrg_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign accept = req_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) state_d = ST_XOR;
      end
      ST_XOR: begin
        if (cnt_q == XorLast) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MUL: begin
        if (cnt_q == MulLast) begin
          cnt_d = '0;
          // fraction and zero span need no remainder
          if (status_i.frac || status_i.span_zero) state_d = ST_DONE;
          else                                     state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.step = cnt_q[1:0];
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        ctrl_o.load = accept;
      end
      ST_XOR:  ctrl_o.xor_en   = 1'b1;
      ST_MUL:  ctrl_o.mul_en   = 1'b1;
      ST_DIV:  ctrl_o.div_en   = 1'b1;
      ST_DONE: ctrl_o.out_load = status_i.out_free;
      default: ctrl_o = '0;
    endcase
  end

  `XRG_ASSERT_NEXT(a_accept_starts_xor, accept, state_q == ST_XOR, "item did not start shifting")
  `XRG_ASSERT_NEXT(a_mul_to_div,
    (state_q == ST_MUL) && (cnt_q == MulLast) && !status_i.frac && !status_i.span_zero,
    state_q == ST_DIV, "integer item skipped the divider")
  `XRG_ASSERT_IMPL(a_out_load_free, ctrl_o.out_load, status_i.out_free,
    "result loaded over an untaken one")

endmodule

// ===== hdl/xrg_datapath.sv =====
`include "xorshift64_star_range_generator_core_defines.svh"

module xrg_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [xrg_pkg::DataW-1:0] cfg_wdata_i,
  input  logic                      req_cmd_i,
  input  logic [xrg_pkg::DataW-1:0] req_range_low_i,
  input  logic [xrg_pkg::DataW-1:0] req_range_high_i,
  input  xrg_pkg::ctrl_t            ctrl_i,
  output xrg_pkg::status_t          status_o,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output logic [xrg_pkg::DataW-1:0] rsp_value_o,
  output logic [xrg_pkg::FracW-1:0] rsp_fraction_o,
  output logic                      rsp_span_error_o
);
  import xrg_pkg::*;

  logic [DataW-1:0] gen_state_q, gen_state_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] prod_q, prod_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] span_q, low_q;
  logic             cmd_q;

  logic [DataW-1:0] xs_val;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [DataW-1:0] acc_sum;
  logic [DataW:0]   rem_shift;
  logic [DataW+1:0] rem_diff;

  logic             valid_q;
  logic [DataW-1:0] value_q, value_d;
  logic [FracW-1:0] fraction_q, fraction_d;
  logic             err_q, err_d;

  // shared shift unit, one xorshift step per cycle
  always_comb begin
    case (ctrl_i.step)
      Step0:   xs_val = gen_state_q ^ (gen_state_q >> ShiftA);
      Step1:   xs_val = gen_state_q ^ (gen_state_q << ShiftB);
      Step2:   xs_val = gen_state_q ^ (gen_state_q >> ShiftC);
      default: xs_val = gen_state_q;
    endcase
  end

  // shared 32x32 multiplier; only low 64 bits of the full product matter
  always_comb begin
    case (ctrl_i.step)
      Step0: begin
        mul_a = gen_state_q[HalfW-1:0];
        mul_b = MixMult[HalfW-1:0];
      end
      Step1: begin
        mul_a = gen_state_q[DataW-1:HalfW];
        mul_b = MixMult[HalfW-1:0];
      end
      Step2: begin
        mul_a = gen_state_q[HalfW-1:0];
        mul_b = MixMult[DataW-1:HalfW];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign acc_sum = acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};

  // restoring division keeping only the remainder, one quotient bit per cycle
  assign rem_shift = {rem_q, acc_q[DataW-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, span_q};

  always_comb begin
    gen_state_d = gen_state_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    if (cfg_we_i) begin
      gen_state_d = cfg_wdata_i;
    end
    if (ctrl_i.load) begin
      rem_d = '0;
    end
    if (ctrl_i.xor_en) begin
      gen_state_d = xs_val;
    end
    if (ctrl_i.mul_en) begin
      case (ctrl_i.step)
        Step0:   acc_d = acc_q;
        Step1:   acc_d = prod_q;
        Step2:   acc_d = acc_sum;
        Step3: begin
          acc_d       = acc_sum;
          gen_state_d = acc_sum;
        end
        default: acc_d = acc_q;
      endcase
    end
    if (ctrl_i.div_en) begin
      acc_d = acc_q << 1;
      if (!rem_diff[DataW+1]) rem_d = rem_diff[DataW-1:0];
      else                    rem_d = rem_shift[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_state_q <= SeedReset;
    end else begin
      gen_state_q <= gen_state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    if (ctrl_i.load) begin
      cmd_q  <= req_cmd_i;
      low_q  <= req_range_low_i;
      span_q <= req_range_high_i - req_range_low_i;
    end
  end

  assign status_o.frac      = (cmd_q == CmdFrac);
  assign status_o.span_zero = (span_q == '0);
  assign status_o.out_free  = !valid_q || rsp_ready_i;

  always_comb begin
    value_d    = '0;
    fraction_d = '0;
    err_d      = 1'b0;
    if (cmd_q == CmdFrac) begin
      fraction_d = gen_state_q[FracW-1:0];
    end else if (span_q == '0) begin
      value_d = low_q;
      err_d   = 1'b1;
    end else begin
      value_d = low_q + rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      value_q    <= value_d;
      fraction_q <= fraction_d;
      err_q      <= err_d;
    end
  end

  assign rsp_valid_o      = valid_q;
  assign rsp_value_o      = value_q;
  assign rsp_fraction_o   = fraction_q;
  assign rsp_span_error_o = err_q;

  `XRG_ASSERT_IMPL(a_rem_below_span, ctrl_i.div_en, rem_q < span_q,
    "partial remainder not below span")
  `XRG_ASSERT_NEXT(a_frac_value_zero, ctrl_i.out_load && (cmd_q == CmdFrac),
    (value_q == '0) && !err_q, "fraction result carries integer fields")
  `XRG_ASSERT_NEXT(a_err_gives_low, ctrl_i.out_load && err_d, value_q == low_q,
    "zero span result is not the low bound")

endmodule
